// ===== design/ycp_pkg.sv =====
// Shared types, constants and helpers for the YCbCr to RGB sample packer.
`timescale 1ns / 1ps

package ycp_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int PREC_W     = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CHROMA_W   = 34;   // centered chroma, signed
    localparam int COEF_W     = 18;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 52;   // coefficient products and green sum
    localparam int TRUNC_W    = 36;   // truncated offsets and luma sums

    localparam logic [CFG_ADDR_W-1:0] REG_PRECISION  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_CODE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIG_ENDIAN = 2'd2;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;

    localparam logic [PREC_W-1:0] PRECISION_RESET  = 6'd8;
    localparam logic [PREC_W-1:0] PRECISION_MAX    = 6'd32;
    localparam logic [1:0]        WIDTH_CODE_RESET = WIDTH_8;

    // 1.402, 0.344, 0.714, 1.772 in Q16
    localparam logic signed [COEF_W-1:0] COEF_CR_R = 18'sd91881;
    localparam logic signed [COEF_W-1:0] COEF_CB_G = 18'sd22544;
    localparam logic signed [COEF_W-1:0] COEF_CR_G = 18'sd46793;
    localparam logic signed [COEF_W-1:0] COEF_CB_B = 18'sd116130;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] blue_diff;
        logic [SAMPLE_W-1:0] red_diff;
    } pixel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [PREC_W-1:0] precision;
        logic [1:0]        sample_width_code;
        logic              big_endian;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]      luma;
        logic signed [PROD_W-1:0] r_prod;
        logic signed [PROD_W-1:0] g_prod;
        logic signed [PROD_W-1:0] b_prod;
    } prod_t;

    // precision 0 acts as 1, above 32 acts as 32
    function automatic logic [PREC_W-1:0] clamp_precision(input logic [PREC_W-1:0] p);
        logic [PREC_W-1:0] r;
        r = p;
        if (p == '0)
            r = 6'd1;
        else if (p > PRECISION_MAX)
            r = PRECISION_MAX;
        return r;
    endfunction

endpackage

// ===== design/ycp_matrix.sv =====
// Chroma centering, coefficient multiplies and green sum (three stages).
`timescale 1ns / 1ps

module ycp_matrix (
    input  logic           clk,
    input  logic           rst_n,
    input  ycp_pkg::cfg_t  cfg,
    input  logic           pixel_valid,
    output logic           pixel_stall,
    input  ycp_pkg::pixel_t pixel,
    output logic           prod_valid,
    input  logic           prod_stall,
    output ycp_pkg::prod_t prod
);
    import ycp_pkg::*;

    logic                       s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0]        s1_luma_reg, s1_luma_next;
    logic signed [CHROMA_W-1:0] s1_cb_reg, s1_cb_next;
    logic signed [CHROMA_W-1:0] s1_cr_reg, s1_cr_next;

    logic                       s2_valid_reg, s2_valid_next;
    logic [SAMPLE_W-1:0]        s2_luma_reg, s2_luma_next;
    logic signed [PROD_W-1:0]   s2_r_reg, s2_r_next;
    logic signed [PROD_W-1:0]   s2_gb_reg, s2_gb_next;
    logic signed [PROD_W-1:0]   s2_gr_reg, s2_gr_next;
    logic signed [PROD_W-1:0]   s2_b_reg, s2_b_next;

    logic                       s3_valid_reg, s3_valid_next;
    prod_t                      s3_prod_reg, s3_prod_next;

    logic adv1, adv2, adv3;
    logic [PREC_W-1:0]   prec;
    logic [CHROMA_W-1:0] offset;

    // a stage moves when it is empty or the one after it moves
    assign adv3 = !s3_valid_reg || !prod_stall;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign pixel_stall = !adv1;

    assign prec   = clamp_precision(cfg.precision);
    assign offset = CHROMA_W'(1) << (prec - 6'd1);

    always_comb
    begin
        s1_valid_next = adv1 ? pixel_valid : s1_valid_reg;
        s1_luma_next  = pixel.luma;
        s1_cb_next    = signed'({2'b00, pixel.blue_diff}) - signed'(offset);
        s1_cr_next    = signed'({2'b00, pixel.red_diff}) - signed'(offset);

        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
        s2_luma_next  = s1_luma_reg;
        s2_r_next     = PROD_W'(s1_cr_reg) * PROD_W'(COEF_CR_R);
        s2_gb_next    = PROD_W'(s1_cb_reg) * PROD_W'(COEF_CB_G);
        s2_gr_next    = PROD_W'(s1_cr_reg) * PROD_W'(COEF_CR_G);
        s2_b_next     = PROD_W'(s1_cb_reg) * PROD_W'(COEF_CB_B);

        s3_valid_next       = adv3 ? s2_valid_reg : s3_valid_reg;
        s3_prod_next.luma   = s2_luma_reg;
        s3_prod_next.r_prod = s2_r_reg;
        s3_prod_next.g_prod = s2_gb_reg + s2_gr_reg;
        s3_prod_next.b_prod = s2_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_luma_reg <= s1_luma_next;
            s1_cb_reg   <= s1_cb_next;
            s1_cr_reg   <= s1_cr_next;
        end
        if (adv2)
        begin
            s2_luma_reg <= s2_luma_next;
            s2_r_reg    <= s2_r_next;
            s2_gb_reg   <= s2_gb_next;
            s2_gr_reg   <= s2_gr_next;
            s2_b_reg    <= s2_b_next;
        end
        if (adv3)
            s3_prod_reg <= s3_prod_next;
    end

    assign prod_valid = s3_valid_reg;
    assign prod       = s3_prod_reg;

endmodule

// ===== design/ycp_round_sat.sv =====
// Truncation toward zero, luma add and precision saturation (two stages).
`timescale 1ns / 1ps

module ycp_round_sat (
    input  logic           clk,
    input  logic           rst_n,
    input  ycp_pkg::cfg_t  cfg,
    input  logic           prod_valid,
    output logic           prod_stall,
    input  ycp_pkg::prod_t prod,
    output logic           sat_valid,
    input  logic           sat_stall,
    output ycp_pkg::rgb_t  sat
);
    import ycp_pkg::*;

    logic                      s4_valid_reg, s4_valid_next;
    logic [SAMPLE_W-1:0]       s4_luma_reg, s4_luma_next;
    logic signed [TRUNC_W-1:0] s4_r_reg, s4_r_next;
    logic signed [TRUNC_W-1:0] s4_g_reg, s4_g_next;
    logic signed [TRUNC_W-1:0] s4_b_reg, s4_b_next;

    logic                      s5_valid_reg, s5_valid_next;
    rgb_t                      s5_rgb_reg, s5_rgb_next;

    logic adv4, adv5;
    logic [PREC_W-1:0]   prec;
    logic [SAMPLE_W-1:0] ceiling;
    logic signed [TRUNC_W-1:0] luma_s;

    assign adv5 = !s5_valid_reg || !sat_stall;
    assign adv4 = !s4_valid_reg || adv5;
    assign prod_stall = !adv4;

    assign prec    = clamp_precision(cfg.precision);
    assign ceiling = SAMPLE_W'((33'(1) << prec) - 33'(1));
    assign luma_s  = signed'({4'b0000, s4_luma_reg});

    // Q16 product to integer, rounding toward zero
    function automatic logic signed [TRUNC_W-1:0] trunc_frac(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p + signed'(PROD_W'({FRAC_W{p[PROD_W-1]}}));
        return TRUNC_W'(biased >>> FRAC_W);
    endfunction

    function automatic logic [SAMPLE_W-1:0] saturate(input logic signed [TRUNC_W-1:0] v,
                                                     input logic [SAMPLE_W-1:0] ceil_v);
        logic [SAMPLE_W-1:0] r;
        if (v[TRUNC_W-1])
            r = '0;
        else if (v[TRUNC_W-2:0] > (TRUNC_W-1)'(ceil_v))
            r = ceil_v;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        s4_valid_next = adv4 ? prod_valid : s4_valid_reg;
        s4_luma_next  = prod.luma;
        s4_r_next     = trunc_frac(prod.r_prod);
        s4_g_next     = trunc_frac(prod.g_prod);
        s4_b_next     = trunc_frac(prod.b_prod);

        s5_valid_next     = adv5 ? s4_valid_reg : s5_valid_reg;
        s5_rgb_next.red   = saturate(luma_s + s4_r_reg, ceiling);
        s5_rgb_next.green = saturate(luma_s - s4_g_reg, ceiling);
        s5_rgb_next.blue  = saturate(luma_s + s4_b_reg, ceiling);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            s4_luma_reg <= s4_luma_next;
            s4_r_reg    <= s4_r_next;
            s4_g_reg    <= s4_g_next;
            s4_b_reg    <= s4_b_next;
        end
        if (adv5)
            s5_rgb_reg <= s5_rgb_next;
    end

    assign sat_valid = s5_valid_reg;
    assign sat       = s5_rgb_reg;

endmodule

// ===== design/ycp_packer.sv =====
// Output register: width clamp and byte order of each sample word.
`timescale 1ns / 1ps

module ycp_packer (
    input  logic          clk,
    input  logic          rst_n,
    input  ycp_pkg::cfg_t cfg,
    input  logic          sat_valid,
    output logic          sat_stall,
    input  ycp_pkg::rgb_t sat,
    output logic          rgb_valid,
    input  logic          rgb_stall,
    output ycp_pkg::rgb_t rgb
);
    import ycp_pkg::*;

    logic out_valid_reg, out_valid_next;
    rgb_t out_rgb_reg, out_rgb_next;
    logic adv;

    function automatic logic [SAMPLE_W-1:0] pack_sample(input logic [SAMPLE_W-1:0] v,
                                                        input cfg_t c);
        logic [SAMPLE_W-1:0] w;
        unique case (c.sample_width_code)
            WIDTH_8:
            begin
                w = (v > 32'd255) ? 32'd255 : v;
            end
            WIDTH_16:
            begin
                w = (v > 32'd65535) ? 32'd65535 : v;
                if (c.big_endian)
                    w = {16'h0000, w[7:0], w[15:8]};
            end
            default:
            begin
                w = c.big_endian ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
            end
        endcase
        return w;
    endfunction

    assign adv       = !out_valid_reg || !rgb_stall;
    assign sat_stall = !adv;

    always_comb
    begin
        out_valid_next     = adv ? sat_valid : out_valid_reg;
        out_rgb_next.red   = pack_sample(sat.red, cfg);
        out_rgb_next.green = pack_sample(sat.green, cfg);
        out_rgb_next.blue  = pack_sample(sat.blue, cfg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_rgb_reg <= out_rgb_next;
    end

    assign rgb_valid = out_valid_reg;
    assign rgb       = out_rgb_reg;

endmodule

// ===== design/ycbcr_to_rgb_sample_packer.sv =====
// Top level: YCbCr to RGB conversion with sample packing, six-stage pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Word
// pixel     in         pixel_valid/pixel_stall   luma, blue_diff, red_diff
// rgb       out        rgb_valid/rgb_stall       red, green, blue
// cfg       in         cfg_write                 cfg_index, cfg_data
//
// One pixel per clock sustained while rgb_stall is low. The accepting edge
// loads the first of six register stages (center, multiply, green sum,
// truncate, saturate, pack), and rgb_valid rises as the pack stage loads.
// Reset clears every valid bit and loads the config defaults (precision 8,
// 8-bit samples, little-endian). A stall on rgb backs up only as far as the
// first empty stage, so bubbles collapse and no word is lost or repeated.

module ycbcr_to_rgb_sample_packer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ycp_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [ycp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  ycp_pkg::pixel_t                    pixel,
    output logic                               rgb_valid,
    input  logic                               rgb_stall,
    output ycp_pkg::rgb_t                      rgb
);
    import ycp_pkg::*;

    // configuration; only written while the pipe is empty, a rule on the user that the block leaves unchecked
    cfg_t cfg_reg, cfg_next;

    logic  prod_valid, prod_stall;
    prod_t prod;
    logic  sat_valid, sat_stall;
    rgb_t  sat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRECISION:  cfg_next.precision         = cfg_data[PREC_W-1:0];
                REG_WIDTH_CODE: cfg_next.sample_width_code = cfg_data[1:0];
                REG_BIG_ENDIAN: cfg_next.big_endian        = cfg_data[0];
                default:        cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.precision         <= PRECISION_RESET;
            cfg_reg.sample_width_code <= WIDTH_CODE_RESET;
            cfg_reg.big_endian        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stages 1-3: center chroma, Q16 multiplies, green sum
    ycp_matrix u_matrix (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .prod_valid  (prod_valid),
        .prod_stall  (prod_stall),
        .prod        (prod)
    );

    // stages 4-5: truncate toward zero, add luma, clamp to 0..2^prec-1
    ycp_round_sat u_round_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod),
        .sat_valid  (sat_valid),
        .sat_stall  (sat_stall),
        .sat        (sat)
    );

    // stage 6: output width clamp and byte swap
    ycp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sat_valid (sat_valid),
        .sat_stall (sat_stall),
        .sat       (sat),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

endmodule

// ===== design/ycp_checker.sv =====
// Port-level checks for the sample packer, bound to the top level.
`timescale 1ns / 1ps

module ycp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_write,
    input logic [ycp_pkg::CFG_ADDR_W-1:0] cfg_index,
    input logic [ycp_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                           pixel_valid,
    input logic                           pixel_stall,
    input logic                           rgb_valid,
    input logic                           rgb_stall,
    input ycp_pkg::rgb_t                  rgb
);
    import ycp_pkg::*;

    logic [1:0] width_code_reg;
    logic [3:0] pending_reg, pending_next;
    logic       pixel_acc, rgb_acc;

    assign pixel_acc = pixel_valid && !pixel_stall;
    assign rgb_acc   = rgb_valid && !rgb_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (pixel_acc && !rgb_acc)
            pending_next = pending_reg + 4'd1;
        else if (!pixel_acc && rgb_acc)
            pending_next = pending_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg <= WIDTH_CODE_RESET;
            pending_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_write && cfg_index == REG_WIDTH_CODE)
                width_code_reg <= cfg_data[1:0];
        end
    end

    // a held word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid)
        else $error("rgb_valid dropped while stalled");

    // every result traces back to an accepted pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> pending_reg != 4'd0)
        else $error("rgb word without an accepted pixel");

    // 8-bit samples leave the upper bits clear
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && width_code_reg == WIDTH_8 |->
            rgb.red[31:8] == '0 && rgb.green[31:8] == '0 && rgb.blue[31:8] == '0)
        else $error("8-bit sample has bits above bit 7");

    // 16-bit samples leave the upper half clear
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && width_code_reg == WIDTH_16 |->
            rgb.red[31:16] == '0 && rgb.green[31:16] == '0 && rgb.blue[31:16] == '0)
        else $error("16-bit sample has bits above bit 15");

endmodule

bind ycbcr_to_rgb_sample_packer ycp_checker u_ycp_checker (.*);
